// ===== hdl/kdhr_pkg.sv =====
// ----------------------------------------------------------------------------
// kdhr_pkg
// Shared types and constants for the key debounce and HID report builder:
// sample and report payloads, per-key memory entry, HID usage codes.
// ----------------------------------------------------------------------------
package kdhr_pkg;

  // default geometry
  localparam int unsigned SCANNED_KEYS = 120;
  localparam int unsigned REPORT_SLOTS = 6;
  localparam int unsigned MAX_SLOTS    = 6;

  // compare width for a key index against the key count (holds up to 511)
  localparam int unsigned KEY_CMP_W = 9;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned FILL_W    = 3;

  // debounce register reset value in ms
  localparam logic [7:0] DEBOUNCE_RESET = 8'd10;

  // HID usage codes
  localparam logic [7:0] CODE_MOD_FIRST = 8'hE0;
  localparam logic [7:0] CODE_MOD_LAST  = 8'hE7;
  localparam logic [7:0] CODE_GUI_LEFT  = 8'hE3;
  localparam logic [7:0] CODE_SPACE     = 8'h2C;
  localparam logic [7:0] CODE_COMMA     = 8'h36;

  // one key sample
  typedef struct packed {
    logic [6:0]         key_pos;
    logic               raw_level;
    logic [7:0]         key_code;
    logic [STAMP_W-1:0] now_ms;
    logic               scan_end;
  } key_smp_t;

  // one boot report
  typedef struct packed {
    logic [7:0]        modifier_bits;
    logic [7:0]        slot_a;
    logic [7:0]        slot_b;
    logic [7:0]        slot_c;
    logic [7:0]        slot_d;
    logic [7:0]        slot_e;
    logic [7:0]        slot_f;
    logic [FILL_W-1:0] typed_count;
    logic              game_mode_now;
  } hid_rpt_t;

  // per-key debounce state held in memory
  typedef struct packed {
    logic               raw_seen;
    logic               stable_level;
    logic [STAMP_W-1:0] change_stamp;
    logic               was_pressed;
  } key_ent_t;

endpackage

// ===== hdl/key_debounce_hid_report_builder.sv =====
// A scan-end sample's report passes through the stage-one register and then the output register.
// Throughput: one sample per cycle; the per-key memory read-modify-write uses forwarding
// of the entry written in the same cycle as the next read.
// The input stalls only while a finished report waits on a stalled output.
// Reset: asynchronous, clears per-key valid bits, accumulators, game mode and the
// debounce register (10 ms); ready right after reset.
// ----------------------------------------------------------------------------
// key_debounce_hid_report_builder
// Debounces scanned keys from a per-key memory and builds HID boot reports,
// one report per scan.
// ----------------------------------------------------------------------------
module key_debounce_hid_report_builder #(
  parameter int unsigned ScannedKeys = kdhr_pkg::SCANNED_KEYS,
  parameter int unsigned ReportSlots = kdhr_pkg::REPORT_SLOTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kdhr_pkg::key_smp_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kdhr_pkg::hid_rpt_t out_data_o
);

  localparam int unsigned AddrW  = $clog2(ScannedKeys);
  localparam int unsigned CmpW   = kdhr_pkg::KEY_CMP_W;
  localparam int unsigned StampW = kdhr_pkg::STAMP_W;
  localparam int unsigned FillW  = kdhr_pkg::FILL_W;
  localparam int unsigned MaxSl  = kdhr_pkg::MAX_SLOTS;

  // debounce register
  logic [7:0] deb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= kdhr_pkg::DEBOUNCE_RESET;
    end else if (cfg_we_i) begin
      deb_q <= cfg_wdata_i;
    end
  end

  // input decode
  logic             in_xfer;
  logic [CmpW-1:0]  in_idx;
  logic             in_deb;
  logic [AddrW-1:0] in_addr;

  assign in_xfer = in_valid_i && in_ready_o;
  assign in_idx  = CmpW'(in_data_i.key_pos);
  assign in_deb  = in_idx < CmpW'(ScannedKeys);
  assign in_addr = in_idx[AddrW-1:0];

  // stage one registers
  logic               s1_vld_q;
  kdhr_pkg::key_smp_t s1_q;
  logic               s1_adv;
  logic               fire;
  logic [CmpW-1:0]    s1_idx;
  logic               s1_deb;
  logic               s1_sp;
  logic [AddrW-1:0]   s1_addr;

  assign s1_idx  = CmpW'(s1_q.key_pos);
  assign s1_deb  = s1_idx < CmpW'(ScannedKeys);
  assign s1_sp   = s1_idx == CmpW'(ScannedKeys);
  assign s1_addr = s1_idx[AddrW-1:0];

  // stage advances unless a report has nowhere to go
  assign s1_adv     = !s1_q.scan_end || !out_valid_o || out_ready_i;
  assign fire       = s1_vld_q && s1_adv;
  assign in_ready_o = !s1_vld_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= in_data_i;
    end
  end

  // per-key memory
  kdhr_pkg::key_ent_t rd_data;
  kdhr_pkg::key_ent_t ent_nx;
  logic               wr_en;

  assign wr_en = fire && s1_deb;

  kdhr_key_mem #(
    .Depth (ScannedKeys),
    .AddrW (AddrW)
  ) u_key_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer && in_deb),
    .rd_addr_i (in_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr),
    .wr_data_i (ent_nx)
  );

  // forwarding of an entry written at the edge it was read
  logic               fwd_hit_q;
  kdhr_pkg::key_ent_t fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (in_ready_o) begin
      fwd_hit_q <= in_xfer && in_deb && wr_en && (in_addr == s1_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_data_q <= ent_nx;
    end
  end

  // accumulators
  logic             game_q;
  logic [7:0]       mod_q;
  logic [7:0]       slot_q [ReportSlots];
  logic [FillW-1:0] fill_q;
  logic [FillW-1:0] typed_q;
  logic             sp_was_q;

  // key step: debounce, press decode, report accumulation
  kdhr_pkg::key_ent_t ent;
  logic [StampW-1:0]  elapsed;
  logic               pressed;
  logic               prev_was;
  logic               skip;
  logic               take;
  logic               is_mod;
  logic               place;
  logic               was_nx;
  logic [7:0]         mod_nx;
  logic [7:0]         slot_nx [ReportSlots];
  logic [FillW-1:0]   fill_nx;
  logic [FillW-1:0]   typed_nx;
  logic               game_nx;

  always_comb begin
    ent     = fwd_hit_q ? fwd_data_q : rd_data;
    ent_nx  = ent;
    elapsed = s1_q.now_ms - ent.change_stamp;
    if (s1_q.raw_level != ent.raw_seen) begin
      ent_nx.raw_seen     = s1_q.raw_level;
      ent_nx.change_stamp = s1_q.now_ms;
    end else if (elapsed >= StampW'(deb_q)) begin
      ent_nx.stable_level = ent.raw_seen;
    end

    pressed  = s1_deb ? !ent_nx.stable_level : !s1_q.raw_level;
    prev_was = s1_deb ? ent.was_pressed : sp_was_q;
    skip     = game_q && (s1_q.key_code == kdhr_pkg::CODE_GUI_LEFT);
    take     = (s1_deb || s1_sp) && pressed && !skip;
    is_mod   = s1_q.key_code inside {[kdhr_pkg::CODE_MOD_FIRST : kdhr_pkg::CODE_MOD_LAST]};
    place    = take && !is_mod && (fill_q < FillW'(ReportSlots));

    // a pressed left gui in game mode keeps its previous-state bit
    was_nx           = (pressed && skip) ? prev_was : pressed;
    ent_nx.was_pressed = was_nx;

    mod_nx = mod_q;
    if (take && is_mod) begin
      mod_nx = mod_q | (8'd1 << s1_q.key_code[2:0]);
    end

    for (int k = 0; k < ReportSlots; k++) begin
      slot_nx[k] = slot_q[k];
      if (place && (fill_q == FillW'(k))) begin
        slot_nx[k] = s1_q.key_code;
      end
    end

    fill_nx  = place ? fill_q + FillW'(1) : fill_q;
    typed_nx = (place && !prev_was && (s1_q.key_code != kdhr_pkg::CODE_SPACE)) ?
               typed_q + FillW'(1) : typed_q;

    // ctrl-left with comma in the first slot flips game mode
    game_nx = game_q ^ (mod_nx[0] && (slot_nx[0] == kdhr_pkg::CODE_COMMA));
  end

  // accumulator and mode registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      game_q   <= 1'b0;
      mod_q    <= '0;
      fill_q   <= '0;
      typed_q  <= '0;
      sp_was_q <= 1'b0;
      for (int k = 0; k < ReportSlots; k++) begin
        slot_q[k] <= '0;
      end
    end else if (fire) begin
      if (s1_sp) begin
        sp_was_q <= was_nx;
      end
      if (s1_q.scan_end) begin
        game_q  <= game_nx;
        mod_q   <= '0;
        fill_q  <= '0;
        typed_q <= '0;
        for (int k = 0; k < ReportSlots; k++) begin
          slot_q[k] <= '0;
        end
      end else begin
        mod_q   <= mod_nx;
        fill_q  <= fill_nx;
        typed_q <= typed_nx;
        for (int k = 0; k < ReportSlots; k++) begin
          slot_q[k] <= slot_nx[k];
        end
      end
    end
  end

  // report slots, zero above the configured slot count
  logic [7:0] rpt_slot [MaxSl];

  for (genvar g = 0; g < MaxSl; g++) begin : g_slot
    if (g < ReportSlots) begin : g_used
      assign rpt_slot[g] = slot_nx[g];
    end else begin : g_zero
      assign rpt_slot[g] = '0;
    end
  end

  kdhr_pkg::hid_rpt_t rpt;

  always_comb begin
    rpt.modifier_bits = mod_nx;
    rpt.slot_a        = rpt_slot[0];
    rpt.slot_b        = rpt_slot[1];
    rpt.slot_c        = rpt_slot[2];
    rpt.slot_d        = rpt_slot[3];
    rpt.slot_e        = rpt_slot[4];
    rpt.slot_f        = rpt_slot[5];
    rpt.typed_count   = typed_nx;
    rpt.game_mode_now = game_nx;
  end

  // output register
  logic               out_vld_q;
  kdhr_pkg::hid_rpt_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && s1_q.scan_end) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && s1_q.scan_end) begin
      out_q <= rpt;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/kdhr_key_mem.sv =====
// ----------------------------------------------------------------------------
// kdhr_key_mem
// Per-key state memory: one write port, one read port with registered data.
// An entry never written since reset reads as all zero via its valid bit.
// ----------------------------------------------------------------------------
module kdhr_key_mem #(
  parameter int unsigned Depth = kdhr_pkg::SCANNED_KEYS,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output kdhr_pkg::key_ent_t  rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  kdhr_pkg::key_ent_t  wr_data_i
);

  kdhr_pkg::key_ent_t mem_q [Depth];
  kdhr_pkg::key_ent_t rd_data_q;
  logic [Depth-1:0]   vld_q;
  logic               rd_vld_q;

  // entry valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // registered valid for the read entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hdl/kdhr_chk.sv =====
// ----------------------------------------------------------------------------
// kdhr_chk
// Port-level checks for the key debounce and HID report builder.
// ----------------------------------------------------------------------------
module kdhr_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [7:0]         cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input kdhr_pkg::key_smp_t in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input kdhr_pkg::hid_rpt_t out_data_o
);

  // a waiting report holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("report changed or dropped while stalled");

  // a new report follows an earlier scan-end transfer
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_data_i.scan_end, 2))
    else $error("report without a scan-end transfer");

  // input stalls only behind a blocked report
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // typed count never exceeds the slot count
  a_typed_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.typed_count <= 3'd6)
    else $error("typed count out of range");

endmodule

bind key_debounce_hid_report_builder kdhr_chk u_kdhr_chk (.*);

// ===== tb/kdhr_checker.sv =====
// ----------------------------------------------------------------------------
// kdhr_checker
// Watches the sample, report and debounce register ports of the report
// builder, keeps its own model of per-key debounce state and the report
// accumulators, and compares every report transfer field by field against
// the oldest predicted report.
// ----------------------------------------------------------------------------
module kdhr_checker
  import kdhr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  key_smp_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  hid_rpt_t    out_data_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  // model copy of the debounce register and per-key state
  logic [7:0]   hold_ms;
  logic         key_raw    [SCANNED_KEYS];
  logic         key_stable [SCANNED_KEYS];
  logic [31:0]  key_stamp  [SCANNED_KEYS];
  logic         key_down_prev [SCANNED_KEYS+1];

  // report accumulators
  logic         game_on;
  logic [7:0]   mod_acc;
  logic [7:0]   slot_acc [MAX_SLOTS];
  int unsigned  slot_cnt;
  logic [2:0]   typed_acc;

  hid_rpt_t     report_q [$];
  int unsigned  mismatch_cnt;

  // one debounced or raw key level folded into the accumulators
  task automatic fold_key(input int unsigned kidx, input logic down, input logic [7:0] code);
    if (down) begin
      // left gui is masked out while gaming, previous state untouched
      if (game_on && code == CODE_GUI_LEFT) return;
      if (code >= CODE_MOD_FIRST && code <= CODE_MOD_LAST) begin
        mod_acc = mod_acc | (8'h01 << code[2:0]);
      end else if (slot_cnt < REPORT_SLOTS) begin
        slot_acc[slot_cnt] = code;
        slot_cnt++;
        if (!key_down_prev[kidx] && code != CODE_SPACE) typed_acc++;
      end
    end
    key_down_prev[kidx] = down;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%02h, actual 0x%02h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // predict on sample transfers, compare on report transfers
  always @(posedge clk_i or negedge rst_ni) begin : model_p
    hid_rpt_t    want;
    hid_rpt_t    rpt;
    int unsigned kidx;
    logic [31:0] elapsed;
    if (!rst_ni) begin
      hold_ms = DEBOUNCE_RESET;
      for (int k = 0; k < SCANNED_KEYS; k++) begin
        key_raw[k]    = 1'b0;
        key_stable[k] = 1'b0;
        key_stamp[k]  = '0;
      end
      for (int k = 0; k <= SCANNED_KEYS; k++) key_down_prev[k] = 1'b0;
      game_on = 1'b0;
      mod_acc = '0;
      for (int k = 0; k < MAX_SLOTS; k++) slot_acc[k] = '0;
      slot_cnt  = 0;
      typed_acc = '0;
      report_q.delete();
      mismatch_cnt = 0;
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (cfg_we_i) hold_ms = cfg_wdata_i;

      // report transfer against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (report_q.size() == 0) begin
          $error("report transfer with no report predicted: 0x%h", out_data_i);
          mismatch_cnt++;
        end else begin
          want = report_q.pop_front();
          check_field("modifier_bits", want.modifier_bits, out_data_i.modifier_bits);
          check_field("slot_a", want.slot_a, out_data_i.slot_a);
          check_field("slot_b", want.slot_b, out_data_i.slot_b);
          check_field("slot_c", want.slot_c, out_data_i.slot_c);
          check_field("slot_d", want.slot_d, out_data_i.slot_d);
          check_field("slot_e", want.slot_e, out_data_i.slot_e);
          check_field("slot_f", want.slot_f, out_data_i.slot_f);
          check_field("typed_count", {5'b0, want.typed_count},
                      {5'b0, out_data_i.typed_count});
          check_field("game_mode_now", {7'b0, want.game_mode_now},
                      {7'b0, out_data_i.game_mode_now});
        end
      end

      // sample transfer: debounce step, accumulate, emit at scan end
      if (in_valid_i && in_ready_i) begin
        kidx = 32'(in_data_i.key_pos);
        if (kidx < SCANNED_KEYS) begin
          elapsed = in_data_i.now_ms - key_stamp[kidx];
          if (in_data_i.raw_level != key_raw[kidx]) begin
            key_raw[kidx]   = in_data_i.raw_level;
            key_stamp[kidx] = in_data_i.now_ms;
          end else if (elapsed >= {24'b0, hold_ms}) begin
            key_stable[kidx] = key_raw[kidx];
          end
          fold_key(kidx, !key_stable[kidx], in_data_i.key_code);
        end else if (kidx == SCANNED_KEYS) begin
          fold_key(kidx, !in_data_i.raw_level, in_data_i.key_code);
        end

        if (in_data_i.scan_end) begin
          // ctrl-left with comma in the first slot flips game mode
          if (mod_acc[0] && slot_acc[0] == CODE_COMMA) game_on = !game_on;
          rpt.modifier_bits = mod_acc;
          rpt.slot_a        = slot_acc[0];
          rpt.slot_b        = slot_acc[1];
          rpt.slot_c        = slot_acc[2];
          rpt.slot_d        = slot_acc[3];
          rpt.slot_e        = slot_acc[4];
          rpt.slot_f        = slot_acc[5];
          rpt.typed_count   = typed_acc;
          rpt.game_mode_now = game_on;
          report_q.push_back(rpt);
          mod_acc = '0;
          for (int k = 0; k < MAX_SLOTS; k++) slot_acc[k] = '0;
          slot_cnt  = 0;
          typed_acc = '0;
        end
      end

      pending_o  <= report_q.size();
      fail_cnt_o <= mismatch_cnt;
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench top for the key debounce and HID report builder: drives key
// samples as scans of varying shape, flow control on both channels and
// debounce register settings; checking is done by the checker beside the DUT.
// ----------------------------------------------------------------------------
module tb;
  import kdhr_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseItems    = 242;
  localparam int unsigned DrainCycles   = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  key_smp_t    in_data;
  logic        out_valid;
  logic        out_ready;
  hid_rpt_t    out_data;
  int unsigned fail_cnt;
  int unsigned pending;

  // stimulus state
  int unsigned feed_gap_pct;
  int unsigned out_stall_pct;
  int unsigned hold_now;
  int unsigned fed_items;
  int unsigned idle_cycles;
  logic [31:0] now_ms;
  logic [7:0]  key_map [128];
  logic        key_phys [128];

  key_debounce_hid_report_builder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  kdhr_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // report receiver with random stalls
  always @(posedge clk_i) begin
    out_ready <= rst_ni && ($urandom_range(0, 99) >= out_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one sample transfer, with random idle cycles in front
  task automatic send_sample(input key_smp_t smp);
    while ($urandom_range(0, 99) < feed_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= smp;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic put(input int unsigned idx, input logic raw, input logic [7:0] code,
                     input logic [31:0] stamp, input logic last);
    key_smp_t smp;
    smp.key_pos   = idx[6:0];
    smp.raw_level = raw;
    smp.key_code  = code;
    smp.now_ms    = stamp;
    smp.scan_end  = last;
    if (idx <= SCANNED_KEYS) fed_items++;
    send_sample(smp);
  endtask

  // hold samples off until all reports are out, then write the register
  task automatic set_hold(input logic [7:0] value);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    hold_now = 32'(value);
  endtask

  // one scan: mostly ordered key subsets, sometimes broken or with ignored positions
  task automatic run_scan();
    int unsigned picks [$];
    int unsigned idx;
    int unsigned pct;
    int unsigned span;
    logic        raw;
    logic [7:0]  code;
    if ($urandom_range(0, 99) < 8) begin
      // broken scan: random positions, repeats and out of order
      repeat ($urandom_range(1, 12)) picks.push_back($urandom_range(0, 127));
    end else begin
      if ($urandom_range(0, 99) < 3) picks.push_back($urandom_range(SCANNED_KEYS + 1, 127));
      for (int k = 0; k <= SCANNED_KEYS; k++) begin
        pct = (k < 10 || k == SCANNED_KEYS) ? 50 : 5;
        if ($urandom_range(0, 99) < pct) picks.push_back(k);
      end
      // scan end on an ignored position, or an empty scan
      if ($urandom_range(0, 99) < 5 || picks.size() == 0) begin
        picks.push_back($urandom_range(SCANNED_KEYS + 1, 127));
      end
    end

    // time between scans, now and then long enough to settle a key
    span = hold_now * 2 + 20;
    if ($urandom_range(0, 99) < 5) begin
      now_ms = now_ms + $urandom_range(0, span);
    end else begin
      now_ms = now_ms + $urandom_range(0, 4);
    end

    for (int k = 0; k < picks.size(); k++) begin
      idx = picks[k];
      if (idx <= SCANNED_KEYS) begin
        if ($urandom_range(0, 99) < 8) key_phys[idx] = !key_phys[idx];
        // contact bounce
        raw = key_phys[idx] ^ ($urandom_range(0, 99) < 6);
      end else begin
        raw = 1'($urandom_range(0, 1));
      end
      code = ($urandom_range(0, 99) < 6) ? 8'($urandom_range(0, 255)) : key_map[idx];
      if ($urandom_range(0, 99) < 2) now_ms = now_ms + 1;
      put(idx, raw, code, now_ms, k == picks.size() - 1);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    fed_items     = 0;
    hold_now      = 32'(DEBOUNCE_RESET);
    now_ms        = '0;
    feed_gap_pct  = 22;
    out_stall_pct = 78;

    // position to usage map: modifiers, comma, left gui and space near the front
    for (int k = 0; k < 128; k++) begin
      key_map[k]  = 8'h04 + 8'(k);
      key_phys[k] = 1'($urandom_range(0, 1));
    end
    key_map[0]            = CODE_MOD_FIRST;
    key_map[1]            = CODE_COMMA;
    key_map[2]            = CODE_GUI_LEFT;
    key_map[3]            = CODE_MOD_FIRST + 8'd1;
    key_map[4]            = CODE_MOD_FIRST + 8'd2;
    key_map[5]            = CODE_MOD_FIRST + 8'd4;
    key_map[6]            = CODE_MOD_FIRST + 8'd5;
    key_map[7]            = CODE_MOD_FIRST + 8'd6;
    key_map[8]            = CODE_MOD_LAST;
    key_map[9]            = CODE_SPACE;
    key_map[SCANNED_KEYS] = CODE_SPACE;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // keys read pressed after reset; ctrl-left plus comma turns game mode on
    put(0, 1'b0, CODE_MOD_FIRST, 32'd0, 1'b0);
    put(1, 1'b0, CODE_COMMA, 32'd0, 1'b0);
    put(2, 1'b0, CODE_GUI_LEFT, 32'd0, 1'b0);
    put(SCANNED_KEYS, 1'b0, CODE_SPACE, 32'd0, 1'b0);
    put(127, 1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    put(5, 1'b1, CODE_MOD_LAST, 32'd0, 1'b0);
    put(10, 1'b0, 8'h0E, 32'd0, 1'b1);

    // game mode: left gui masked, slots overflow, toggle back off
    put(0, 1'b0, CODE_MOD_FIRST, 32'd5, 1'b0);
    put(1, 1'b0, CODE_COMMA, 32'd5, 1'b0);
    put(2, 1'b0, CODE_GUI_LEFT, 32'd5, 1'b0);
    for (int k = 11; k <= 17; k++) put(k, 1'b0, 8'h04 + 8'(k), 32'd5, k == 17);

    // release settles after the hold time, space released, scan ends on ignored slot
    put(5, 1'b1, CODE_MOD_LAST, 32'd20, 1'b0);
    put(SCANNED_KEYS, 1'b1, CODE_SPACE, 32'd20, 1'b0);
    put(0, 1'b0, CODE_MOD_FIRST, 32'd20, 1'b0);
    put(2, 1'b0, CODE_GUI_LEFT, 32'd20, 1'b0);
    put(126, 1'b0, 8'h00, 32'd20, 1'b1);

    // random scans under several debounce settings and flow control mixes
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          feed_gap_pct  = 22;
          out_stall_pct = 78;
        end
        1: begin
          feed_gap_pct  = 78;
          out_stall_pct = 22;
        end
        default: begin
          feed_gap_pct  = 0;
          out_stall_pct = 0;
        end
      endcase
      case (phase)
        0: set_hold(8'd255);
        1: set_hold(8'd0);
        2: set_hold(8'($urandom_range(1, 254)));
        3: set_hold(8'd1);
        4: set_hold(8'($urandom_range(0, 255)));
        default: set_hold(DEBOUNCE_RESET);
      endcase
      if (phase == 1) now_ms = 32'hFFFF_FF80;
      if (phase == 3) now_ms = $urandom();
      begin : phase_b
        int unsigned target;
        target = fed_items + PhaseItems;
        while (fed_items < target) run_scan();
      end
    end

    // drain
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
